/* hw/rtl/kle_pkg.sv */
// ----------------------------------------------------------------------------
// kle_pkg: shared types and constants of the keystroke line editor
// Line capacity, key codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package kle_pkg;

  // Line buffer geometry
  localparam int LINE_CAPACITY = 64;
  localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);

  // Key codes with an editing meaning
  localparam logic [7:0] KEY_LEFT    = 8'h3C;  // '<'
  localparam logic [7:0] KEY_RIGHT   = 8'h3E;  // '>'
  localparam logic [7:0] KEY_DELETE  = 8'h2D;  // '-'
  localparam logic [7:0] KEY_NEWLINE = 8'h0A;  // line feed

  // Controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } kle_state_e;

  // Decoded edit operation
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LEFT,
    OP_RIGHT,
    OP_DELETE,
    OP_INSERT
  } kle_op_e;

  // Controller to datapath
  typedef struct packed {
    logic edit;  // apply the key on the input ports
    logic pop;   // move the head character to the output, shift the line
  } kle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;   // line length is zero
    logic single;  // line length is one
  } kle_stat_t;

  // Letters, digits and newline go into the line
  function automatic logic is_insertable(input logic [7:0] k);
    logic res;
    res = (k == KEY_NEWLINE)
       || (k >= 8'h41 && k <= 8'h5A)
       || (k >= 8'h61 && k <= 8'h7A)
       || (k >= 8'h30 && k <= 8'h39);
    return res;
  endfunction

  // Map a key byte to its edit operation
  function automatic kle_op_e decode_key(input logic [7:0] k);
    kle_op_e op;
    if (k == KEY_LEFT) begin
      op = OP_LEFT;
    end else if (k == KEY_RIGHT) begin
      op = OP_RIGHT;
    end else if (k == KEY_DELETE) begin
      op = OP_DELETE;
    end else if (is_insertable(k)) begin
      op = OP_INSERT;
    end else begin
      op = OP_NONE;
    end
    return op;
  endfunction

endpackage

/* hw/rtl/kle_ctrl.sv */
// ----------------------------------------------------------------------------
// kle_ctrl: handshake controller of the keystroke line editor
// Accepts keys while idle, then drives one character per transfer onto the
// output register until the line is drained.
// ----------------------------------------------------------------------------
module kle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              end_of_line_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  kle_pkg::kle_stat_t stat_i,
  output kle_pkg::kle_cmd_t  cmd_o
);
  import kle_pkg::*;

  kle_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  // Output slot can take a new character this cycle
  assign slot_free = !out_valid_q || !out_stall_i;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.edit = 1'b1;
          if (end_of_line_i) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (stat_i.empty) begin
          state_d = ST_IDLE;
        end else if (slot_free) begin
          cmd_o.pop   = 1'b1;
          out_valid_d = 1'b1;
          if (stat_i.single) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  // A pop never overwrites a character that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |-> slot_free)
    else $error("kle_ctrl: pop while output slot is occupied");

  // Keys are only taken while no line is being drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.edit |-> (state_q == ST_IDLE) && !cmd_o.pop)
    else $error("kle_ctrl: edit outside idle");

  // Draining ends once the last character is popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.pop && stat_i.single) |=> (state_q == ST_IDLE))
    else $error("kle_ctrl: emit did not end after last character");

endmodule

/* hw/rtl/kle_datapath.sv */
// ----------------------------------------------------------------------------
// kle_datapath: line cells, length, cursor and output payload register
// Every cell is a register; insert and delete shift the cells past the
// cursor, and emission shifts the whole line toward cell zero.
// ----------------------------------------------------------------------------
module kle_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         key_i,
  input  kle_pkg::kle_cmd_t  cmd_i,
  output kle_pkg::kle_stat_t stat_o,
  output logic [7:0]         text_char_o,
  output logic               last_char_o
);
  import kle_pkg::*;

  logic [7:0]       cell_q [LINE_CAPACITY];
  logic [7:0]       cell_d [LINE_CAPACITY];
  logic [7:0]       cell_prev [LINE_CAPACITY];
  logic [7:0]       cell_next [LINE_CAPACITY];
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] cursor_q, cursor_d;
  logic [7:0]       char_q;
  logic             last_q;
  kle_op_e          op;
  logic             can_insert;
  logic             can_delete;

  assign op         = decode_key(key_i);
  assign can_insert = (len_q < LEN_W'(LINE_CAPACITY));
  assign can_delete = (cursor_q != '0);

  // Neighbor taps of each cell
  always_comb begin
    for (int i = 0; i < LINE_CAPACITY; i++) begin
      cell_prev[i] = (i == 0) ? cell_q[0] : cell_q[(i == 0) ? 0 : i - 1];
      cell_next[i] = (i == LINE_CAPACITY - 1) ? cell_q[LINE_CAPACITY - 1]
                   : cell_q[(i == LINE_CAPACITY - 1) ? i : i + 1];
    end
  end

  // Next cell contents
  always_comb begin
    for (int i = 0; i < LINE_CAPACITY; i++) begin
      cell_d[i] = cell_q[i];
      if (cmd_i.pop) begin
        cell_d[i] = cell_next[i];
      end else if (cmd_i.edit && op == OP_INSERT && can_insert) begin
        if (LEN_W'(i) == cursor_q) begin
          cell_d[i] = key_i;
        end else if (LEN_W'(i) > cursor_q) begin
          cell_d[i] = cell_prev[i];
        end
      end else if (cmd_i.edit && op == OP_DELETE && can_delete) begin
        if (LEN_W'(i + 1) >= cursor_q) begin
          cell_d[i] = cell_next[i];
        end
      end
    end
  end

  // Next length and cursor
  always_comb begin
    len_d    = len_q;
    cursor_d = cursor_q;
    if (cmd_i.pop) begin
      len_d    = len_q - LEN_W'(1);
      cursor_d = '0;
    end else if (cmd_i.edit) begin
      unique case (op)
        OP_LEFT: begin
          if (can_delete) cursor_d = cursor_q - LEN_W'(1);
        end
        OP_RIGHT: begin
          if (cursor_q < len_q) cursor_d = cursor_q + LEN_W'(1);
        end
        OP_DELETE: begin
          if (can_delete) begin
            cursor_d = cursor_q - LEN_W'(1);
            len_d    = len_q - LEN_W'(1);
          end
        end
        OP_INSERT: begin
          if (can_insert) begin
            cursor_d = cursor_q + LEN_W'(1);
            len_d    = len_q + LEN_W'(1);
          end
        end
        default: begin
          len_d = len_q;
        end
      endcase
    end
  end

  // Line cells, no reset
  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  // Length and cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      cursor_q <= '0;
    end else begin
      len_q    <= len_d;
      cursor_q <= cursor_d;
    end
  end

  // Output payload: load on pop, hold otherwise
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      char_q <= cell_q[0];
      last_q <= stat_o.single;
    end
  end

  assign stat_o.empty  = (len_q == '0);
  assign stat_o.single = (len_q == LEN_W'(1));
  assign text_char_o   = char_q;
  assign last_char_o   = last_q;

  // Cursor stays inside the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= len_q)
    else $error("kle_datapath: cursor beyond line length");

  // Length never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(LINE_CAPACITY))
    else $error("kle_datapath: line length beyond capacity");

  // Pop only from a non-empty line, and it parks the cursor at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> !stat_o.empty ##1 (cursor_q == '0))
    else $error("kle_datapath: bad pop");

endmodule

/* hw/rtl/keystroke_line_editor.sv */
// ----------------------------------------------------------------------------
// keystroke_line_editor: line editor with cursor, one key byte per transfer
// Keeps a line of up to LINE_CAPACITY characters and a cursor; emits the
// edited line on end of line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): key_i and end_of_line_i.
//   '<' '>' move the cursor, '-' deletes before it, letters, digits and
//   newline insert at it (dropped when the line is full).
//   Output channel (out_valid_o / out_stall_i): text_char_o, last_char_o.
//   A key flagged end of line is applied first; the line then drains one
//   character per cycle while the receiver does not stall, from a shift of
//   the cell row toward cell zero, with last_char_o set on the final one.
//   The flagged key moves the controller to its emit state, and each pop
//   there loads the output register. An empty line emits nothing.
//   Keys without the flag are taken back to back; after a flagged key no
//   key is taken until the line has drained, and output stalls delay that.
//   in_stall_o is high while a line drains; a key may be taken while a
//   character still waits in the output register.
//   Reset clears length, cursor and controller state; no clearing pass.
// ----------------------------------------------------------------------------
module keystroke_line_editor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] key_i,
  input  logic       end_of_line_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] text_char_o,
  output logic       last_char_o
);
  import kle_pkg::*;

  kle_cmd_t  cmd;
  kle_stat_t stat;

  // Handshake and sequencing
  kle_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .end_of_line_i (end_of_line_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // Line storage and editing
  kle_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o)
  );

endmodule
